// ----- hdl/assert_macros.svh -----
// assertion helpers for the page tag cache
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define DMPTC_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define DMPTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define DMPTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define DMPTC_ASSERT(label, clk, rst_n, prop, msg)
`define DMPTC_ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg)
`define DMPTC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

// ----- hdl/dmptc_pkg.sv -----
package dmptc_pkg;

    localparam int MAX_ENTRIES = 4096;
    localparam int ADDR_BITS   = 64;
    localparam int HANDLE_BITS = 32;

    localparam int MAX_LOG2    = $clog2(MAX_ENTRIES + 1) - 1;
    localparam int SLOT_W      = MAX_LOG2;
    localparam int IDX_W       = SLOT_W + 1;
    localparam int STORE_DEPTH = 2 ** IDX_W;

    localparam int SIZE_W      = 4;
    localparam int COUNT_W     = 13;
    localparam int NEW_SIZE_W  = 21;
    localparam int LOG_W       = $clog2(NEW_SIZE_W);
    localparam int SHIFT_W     = 5;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;

    localparam logic [SHIFT_W-1:0] PAGE_SHIFT_RESET = SHIFT_W'(12);
    localparam int                 INIT_SIZE_RESET  = 10;
    localparam logic [SIZE_W-1:0]  SIZE_RESET       =
        SIZE_W'((INIT_SIZE_RESET > MAX_LOG2) ? MAX_LOG2 : INIT_SIZE_RESET);

    localparam logic [CFG_IDX_W-1:0] CFG_PAGE_SHIFT = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_INIT_SIZE  = CFG_IDX_W'(1);

    typedef enum logic [1:0] {
        OP_LOOKUP,
        OP_INSERT,
        OP_RESIZE,
        OP_NONE
    } t_op;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_ZERO,
        STAT_CLAMP
    } t_status;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_EXEC,
        S_RZ_CLR,
        S_MV_SRC,
        S_MV_DST,
        S_MV_WR,
        S_COMMIT,
        S_DONE
    } t_state;

    typedef struct packed {
        logic in_ready;
        logic accept;
        logic exec;
        logic init_clr;
        logic rz_clr;
        logic mv_src;
        logic mv_dst;
        logic mv_wr;
        logic commit;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic in_valid;
        logic cfg_reinit;
        logic last_full;
        logic last_new;
        logic last_old;
        logic is_resize;
        logic rz_go;
        logic out_free;
    } t_stat;

endpackage

// ----- hdl/dmptc_if.sv -----
interface dmptc_in_if;
    logic                                  valid;
    logic                                  ready;
    logic [1:0]                            op;
    logic [dmptc_pkg::ADDR_BITS-1:0]       addr;
    logic [dmptc_pkg::HANDLE_BITS-1:0]     handle;
    logic [dmptc_pkg::NEW_SIZE_W-1:0]      new_size;

    modport source (output valid, op, addr, handle, new_size, input ready);
    modport sink (input valid, op, addr, handle, new_size, output ready);
endinterface

interface dmptc_out_if;
    logic                                  valid;
    logic                                  ready;
    logic                                  hit;
    logic [dmptc_pkg::HANDLE_BITS-1:0]     handle_out;
    logic [dmptc_pkg::COUNT_W-1:0]         entry_count;
    logic [1:0]                            status;

    modport source (output valid, hit, handle_out, entry_count, status, input ready);
    modport sink (input valid, hit, handle_out, entry_count, status, output ready);
endinterface

interface dmptc_cfg_if;
    logic                                  valid;
    logic                                  ready;
    logic [dmptc_pkg::CFG_IDX_W-1:0]       index;
    logic [dmptc_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

// ----- hdl/dmptc_ctrl.sv -----
module dmptc_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  dmptc_pkg::t_stat i_stat,
    output dmptc_pkg::t_cmd  o_cmd
);

    dmptc_pkg::t_state r_state;
    dmptc_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= dmptc_pkg::S_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            dmptc_pkg::S_INIT: begin
                o_cmd.init_clr = 1'b1;
                if (i_stat.last_full) begin
                    n_state = dmptc_pkg::S_IDLE;
                end
            end
            dmptc_pkg::S_IDLE: begin
                o_cmd.in_ready = 1'b1;
                if (i_stat.in_valid) begin
                    o_cmd.accept = 1'b1;
                    n_state      = dmptc_pkg::S_EXEC;
                end
            end
            dmptc_pkg::S_EXEC: begin
                o_cmd.exec = 1'b1;
                if (i_stat.is_resize && i_stat.rz_go) begin
                    n_state = dmptc_pkg::S_RZ_CLR;
                end else if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = dmptc_pkg::S_IDLE;
                end else begin
                    n_state = dmptc_pkg::S_DONE;
                end
            end
            dmptc_pkg::S_RZ_CLR: begin
                o_cmd.rz_clr = 1'b1;
                if (i_stat.last_new) begin
                    n_state = dmptc_pkg::S_MV_SRC;
                end
            end
            dmptc_pkg::S_MV_SRC: begin
                o_cmd.mv_src = 1'b1;
                n_state      = dmptc_pkg::S_MV_DST;
            end
            dmptc_pkg::S_MV_DST: begin
                o_cmd.mv_dst = 1'b1;
                n_state      = dmptc_pkg::S_MV_WR;
            end
            dmptc_pkg::S_MV_WR: begin
                o_cmd.mv_wr = 1'b1;
                if (i_stat.last_old) begin
                    n_state = dmptc_pkg::S_COMMIT;
                end else begin
                    n_state = dmptc_pkg::S_MV_SRC;
                end
            end
            dmptc_pkg::S_COMMIT: begin
                o_cmd.commit = 1'b1;
                n_state      = dmptc_pkg::S_DONE;
            end
            dmptc_pkg::S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state        = dmptc_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = dmptc_pkg::S_IDLE;
            end
        endcase
        // size register write restarts the clearing pass
        if (i_stat.cfg_reinit) begin
            o_cmd   = '0;
            n_state = dmptc_pkg::S_INIT;
        end
    end

endmodule

// ----- hdl/dmptc_datapath.sv -----
`include "assert_macros.svh"

module dmptc_datapath (
    input  logic             i_clk,
    input  logic             i_rst_n,
    dmptc_in_if.sink         i_in,
    dmptc_out_if.source      o_out,
    dmptc_cfg_if.sink        i_cfg,
    input  dmptc_pkg::t_cmd  i_cmd,
    output dmptc_pkg::t_stat o_stat
);

    typedef struct packed {
        logic                              valid;
        logic [dmptc_pkg::HANDLE_BITS-1:0] handle;
        logic [dmptc_pkg::ADDR_BITS-1:0]   tag;
    } t_entry;

    typedef struct packed {
        logic                              hit;
        logic [dmptc_pkg::HANDLE_BITS-1:0] handle;
        dmptc_pkg::t_status                status;
    } t_res;

    localparam t_entry C_EMPTY = '{valid: 1'b0, handle: '0, tag: '1};

    function automatic logic [dmptc_pkg::SLOT_W-1:0] size_mask(
        input logic [dmptc_pkg::SIZE_W-1:0] sz
    );
        return (dmptc_pkg::SLOT_W'(1) << sz) - dmptc_pkg::SLOT_W'(1);
    endfunction

    function automatic logic [dmptc_pkg::SLOT_W-1:0] slot_of(
        input logic [dmptc_pkg::ADDR_BITS-1:0] a,
        input logic [dmptc_pkg::SHIFT_W-1:0]   sh,
        input logic [dmptc_pkg::SIZE_W-1:0]    sz
    );
        logic [dmptc_pkg::ADDR_BITS-1:0] sa;
        sa = a >> sh;
        return sa[dmptc_pkg::SLOT_W-1:0] & size_mask(sz);
    endfunction

    function automatic logic [dmptc_pkg::LOG_W-1:0] floor_log2(
        input logic [dmptc_pkg::NEW_SIZE_W-1:0] v
    );
        logic [dmptc_pkg::LOG_W-1:0] n;
        n = '0;
        for (int i = 1; i < dmptc_pkg::NEW_SIZE_W; i++) begin
            if (v[i]) begin
                n = dmptc_pkg::LOG_W'(i);
            end
        end
        return n;
    endfunction

    t_entry r_mem [dmptc_pkg::STORE_DEPTH];
    t_entry r_rdata;
    t_entry r_mv_entry;

    dmptc_pkg::t_op                     r_op;
    logic [dmptc_pkg::ADDR_BITS-1:0]    r_addr;
    logic [dmptc_pkg::HANDLE_BITS-1:0]  r_handle;
    logic [dmptc_pkg::NEW_SIZE_W-1:0]   r_new_size;
    logic [dmptc_pkg::SLOT_W-1:0]       r_slot;
    logic [dmptc_pkg::SLOT_W-1:0]       r_mv_slot;
    logic [dmptc_pkg::SLOT_W-1:0]       r_cnt;
    logic [dmptc_pkg::SHIFT_W-1:0]      r_page_shift;
    logic [dmptc_pkg::SIZE_W-1:0]       r_size_log2;
    logic [dmptc_pkg::SIZE_W-1:0]       r_new_log2;
    logic                               r_bank;
    logic [dmptc_pkg::COUNT_W-1:0]      r_used;
    logic [dmptc_pkg::COUNT_W-1:0]      n_used;
    logic [dmptc_pkg::COUNT_W-1:0]      r_mv_count;
    t_res                               r_res;
    t_res                               n_res;

    logic                               r_out_valid;
    logic                               r_out_hit;
    logic [dmptc_pkg::HANDLE_BITS-1:0]  r_out_handle;
    logic [dmptc_pkg::COUNT_W-1:0]      r_out_count;
    dmptc_pkg::t_status                 r_out_status;

    logic                               w_cfg_wr;
    logic                               w_reinit;
    logic [dmptc_pkg::SIZE_W-1:0]       w_cfg_size;
    logic [dmptc_pkg::SLOT_W-1:0]       w_in_slot;
    logic [dmptc_pkg::SLOT_W-1:0]       w_mv_dst_slot;
    logic [dmptc_pkg::LOG_W-1:0]        w_floor;
    logic                               w_clamp;
    logic                               w_rz_zero;
    logic [dmptc_pkg::SIZE_W-1:0]       w_rz_log2;
    logic                               w_mv_write;
    logic                               w_re;
    logic [dmptc_pkg::IDX_W-1:0]        w_rd_addr;
    logic                               w_we;
    logic [dmptc_pkg::IDX_W-1:0]        w_waddr;
    t_entry                             w_wdata;
    t_res                               w_res_sel;
    logic [dmptc_pkg::COUNT_W-1:0]      w_count_sel;

    // configuration port
    assign i_cfg.ready = 1'b1;
    assign w_cfg_wr    = i_cfg.valid & i_cfg.ready;
    assign w_reinit    = w_cfg_wr && (i_cfg.index == dmptc_pkg::CFG_INIT_SIZE);
    assign w_cfg_size  =
        (i_cfg.data[dmptc_pkg::SIZE_W-1:0] > dmptc_pkg::SIZE_W'(dmptc_pkg::MAX_LOG2)) ?
        dmptc_pkg::SIZE_W'(dmptc_pkg::MAX_LOG2) : i_cfg.data[dmptc_pkg::SIZE_W-1:0];

    assign i_in.ready    = i_cmd.in_ready;
    assign w_in_slot     = slot_of(i_in.addr, r_page_shift, r_size_log2);
    assign w_mv_dst_slot = slot_of(r_rdata.tag, r_page_shift, r_new_log2);

    // resize decision
    assign w_floor   = floor_log2(r_new_size);
    assign w_clamp   = w_floor > dmptc_pkg::LOG_W'(dmptc_pkg::MAX_LOG2);
    assign w_rz_zero = (r_new_size == '0);
    assign w_rz_log2 = w_clamp ? dmptc_pkg::SIZE_W'(dmptc_pkg::MAX_LOG2) :
                                 w_floor[dmptc_pkg::SIZE_W-1:0];

    always_comb begin
        n_res  = '0;
        n_used = r_used;
        case (r_op)
            dmptc_pkg::OP_LOOKUP: begin
                n_res.hit    = r_rdata.valid && (r_rdata.tag == r_addr);
                n_res.handle = r_rdata.handle;
            end
            dmptc_pkg::OP_INSERT: begin
                n_res.handle = r_handle;
                if (r_rdata.handle == '0 && r_handle != '0) begin
                    n_used = r_used + dmptc_pkg::COUNT_W'(1);
                end else if (r_rdata.handle != '0 && r_handle == '0) begin
                    n_used = r_used - dmptc_pkg::COUNT_W'(1);
                end
            end
            dmptc_pkg::OP_RESIZE: begin
                if (w_rz_zero) begin
                    n_res.status = dmptc_pkg::STAT_ZERO;
                end else if (w_clamp) begin
                    n_res.status = dmptc_pkg::STAT_CLAMP;
                end
            end
            default: begin
            end
        endcase
    end

    // memory ports
    assign w_mv_write = r_mv_entry.valid && (r_rdata.handle == '0);
    assign w_re       = i_cmd.accept | i_cmd.mv_src | i_cmd.mv_dst;

    always_comb begin
        if (i_cmd.mv_src) begin
            w_rd_addr = {r_bank, r_cnt};
        end else if (i_cmd.mv_dst) begin
            w_rd_addr = {~r_bank, w_mv_dst_slot};
        end else begin
            w_rd_addr = {r_bank, w_in_slot};
        end
    end

    always_comb begin
        w_we    = 1'b0;
        w_waddr = {r_bank, r_slot};
        w_wdata = '{valid: 1'b1, handle: r_handle, tag: r_addr};
        if (i_cmd.init_clr) begin
            w_we    = 1'b1;
            w_waddr = {1'b0, r_cnt};
            w_wdata = C_EMPTY;
        end else if (i_cmd.rz_clr) begin
            w_we    = 1'b1;
            w_waddr = {~r_bank, r_cnt};
            w_wdata = C_EMPTY;
        end else if (i_cmd.mv_wr) begin
            w_we    = w_mv_write;
            w_waddr = {~r_bank, r_mv_slot};
            w_wdata = r_mv_entry;
        end else if (i_cmd.exec && r_op == dmptc_pkg::OP_INSERT) begin
            w_we = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            r_mem[w_waddr] <= w_wdata;
        end
        if (w_re) begin
            r_rdata <= r_mem[w_rd_addr];
        end
    end

    // transaction payload and scratch registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op       <= dmptc_pkg::t_op'(i_in.op);
            r_addr     <= i_in.addr;
            r_handle   <= i_in.handle;
            r_new_size <= i_in.new_size;
            r_slot     <= w_in_slot;
        end
        if (i_cmd.exec) begin
            r_res      <= n_res;
            r_new_log2 <= w_rz_log2;
            r_mv_count <= '0;
        end
        if (i_cmd.mv_dst) begin
            r_mv_entry <= r_rdata;
            r_mv_slot  <= w_mv_dst_slot;
        end
        if (i_cmd.mv_wr && w_mv_write && r_mv_entry.handle != '0) begin
            r_mv_count <= r_mv_count + dmptc_pkg::COUNT_W'(1);
        end
    end

    // cache control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_page_shift <= dmptc_pkg::PAGE_SHIFT_RESET;
            r_size_log2  <= dmptc_pkg::SIZE_RESET;
            r_bank       <= 1'b0;
            r_used       <= '0;
            r_cnt        <= '0;
        end else begin
            if (w_cfg_wr && i_cfg.index == dmptc_pkg::CFG_PAGE_SHIFT) begin
                r_page_shift <= i_cfg.data[dmptc_pkg::SHIFT_W-1:0];
            end
            if (w_reinit) begin
                r_size_log2 <= w_cfg_size;
                r_bank      <= 1'b0;
                r_used      <= '0;
                r_cnt       <= '0;
            end else begin
                if (i_cmd.exec) begin
                    r_used <= n_used;
                end
                if (i_cmd.init_clr) begin
                    r_cnt <= r_cnt + dmptc_pkg::SLOT_W'(1);
                end
                if (i_cmd.rz_clr) begin
                    r_cnt <= o_stat.last_new ? '0 : r_cnt + dmptc_pkg::SLOT_W'(1);
                end
                if (i_cmd.mv_wr) begin
                    r_cnt <= o_stat.last_old ? '0 : r_cnt + dmptc_pkg::SLOT_W'(1);
                end
                if (i_cmd.commit) begin
                    r_bank      <= ~r_bank;
                    r_size_log2 <= r_new_log2;
                    r_used      <= r_mv_count;
                end
            end
        end
    end

    // output register
    assign w_res_sel   = i_cmd.exec ? n_res : r_res;
    assign w_count_sel = i_cmd.exec ? n_used : r_used;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_hit    <= w_res_sel.hit;
            r_out_handle <= w_res_sel.handle;
            r_out_count  <= w_count_sel;
            r_out_status <= w_res_sel.status;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.hit         = r_out_hit;
    assign o_out.handle_out  = r_out_handle;
    assign o_out.entry_count = r_out_count;
    assign o_out.status      = r_out_status;

    // status to the controller
    assign o_stat.in_valid   = i_in.valid;
    assign o_stat.cfg_reinit = w_reinit;
    assign o_stat.last_full  = (r_cnt == '1);
    assign o_stat.last_new   = (r_cnt == size_mask(r_new_log2));
    assign o_stat.last_old   = (r_cnt == size_mask(r_size_log2));
    assign o_stat.is_resize  = (r_op == dmptc_pkg::OP_RESIZE);
    assign o_stat.rz_go      = !w_rz_zero && (w_rz_log2 != r_size_log2);
    assign o_stat.out_free   = !r_out_valid || o_out.ready;

    `DMPTC_ASSERT_NEXT(a_insert_count, i_clk, i_rst_n, i_cmd.exec && r_op == dmptc_pkg::OP_INSERT && r_rdata.handle == '0 && r_handle != '0, r_used == $past(r_used) + dmptc_pkg::COUNT_W'(1), "insert into empty slot did not count")
    `DMPTC_ASSERT_NEXT(a_commit_bank, i_clk, i_rst_n, i_cmd.commit, r_bank != $past(r_bank), "rehash commit did not switch bank")
    `DMPTC_ASSERT_IMPLY(a_out_overwrite, i_clk, i_rst_n, i_cmd.out_load, !r_out_valid || o_out.ready, "result register overwritten before taken")
    `DMPTC_ASSERT(a_used_bound, i_clk, i_rst_n, r_used <= (dmptc_pkg::COUNT_W'(1) << r_size_log2), "entry count exceeds active slot count")

endmodule

// ----- hdl/direct_mapped_page_tag_cache.sv -----
// direct-mapped page tag cache
//
// channels: i_in takes one transaction per item (op, addr, handle, new_size),
// o_out returns exactly one result (hit, handle_out, entry_count, status) per
// item, i_cfg writes page_shift (index 0) or initial_size_log2 (index 1)
// lookup and insert: accepted in S_IDLE with the memory read issued, checked or
// written in S_EXEC, where the result is registered; a new item is taken only
// once the controller is back in S_IDLE
// resize: when rejected (new_size of zero) or of the same size, answered from
// S_EXEC; otherwise a clear of the target bank, then a read/read/write walk
// over the old bank (S_MV_SRC, S_MV_DST, S_MV_WR), then S_COMMIT to swap banks
// reset: a clearing pass over all 2^12 slots of the first bank, i_in not ready;
// a write to initial_size_log2 restarts the same pass and drops an item in flight
// stall: the result waits in the output register while o_out.ready is low;
// the next item is still accepted, and its result is held back until the
// register is free
module direct_mapped_page_tag_cache (
    input  logic        i_clk,
    input  logic        i_rst_n,
    dmptc_in_if.sink    i_in,
    dmptc_out_if.source o_out,
    dmptc_cfg_if.sink   i_cfg
);

    dmptc_pkg::t_cmd  w_cmd;
    dmptc_pkg::t_stat w_stat;

    dmptc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_stat  (w_stat),
        .o_cmd   (w_cmd)
    );

    dmptc_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .o_out   (o_out),
        .i_cfg   (i_cfg),
        .i_cmd   (w_cmd),
        .o_stat  (w_stat)
    );

endmodule

// ----- dv/tb_top.sv -----
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dmptc_pkg::*;

    localparam int IDLE_PCT       = 22;
    localparam int WATCHDOG_LIMIT = 200_000;
    localparam int PHASE_ITEMS    = 215;
    localparam int PHASES         = 5;
    localparam int POOL_DEPTH     = 48;
    localparam int MAX_PRINTS     = 40;
    localparam int DRAIN_CYCLES   = 20;

    typedef struct packed {
        t_op                    op;
        logic [ADDR_BITS-1:0]   addr;
        logic [HANDLE_BITS-1:0] handle;
        logic [NEW_SIZE_W-1:0]  new_size;
    } cache_req_t;

    typedef struct packed {
        logic                   hit;
        logic [HANDLE_BITS-1:0] handle_out;
        logic [COUNT_W-1:0]     entry_count;
        t_status                status;
    } cache_result_t;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    logic                   in_valid    = 1'b0;
    t_op                    in_op       = OP_LOOKUP;
    logic [ADDR_BITS-1:0]   in_addr     = '0;
    logic [HANDLE_BITS-1:0] in_handle   = '0;
    logic [NEW_SIZE_W-1:0]  in_new_size = '0;
    logic                   out_ready   = 1'b0;
    logic                   cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index   = CFG_PAGE_SHIFT;
    logic [CFG_DATA_W-1:0]  cfg_data    = '0;

    logic in_fire  = 1'b0;
    logic cfg_fire = 1'b0;
    bit   no_idle  = 1'b0;

    dmptc_in_if  in_if ();
    dmptc_out_if out_if ();
    dmptc_cfg_if cfg_if ();

    assign in_if.valid     = in_valid;
    assign in_if.op        = in_op;
    assign in_if.addr      = in_addr;
    assign in_if.handle    = in_handle;
    assign in_if.new_size  = in_new_size;
    assign out_if.ready    = out_ready;
    assign cfg_if.valid    = cfg_valid;
    assign cfg_if.index    = cfg_index;
    assign cfg_if.data     = cfg_data;

    direct_mapped_page_tag_cache dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    // page cache shadow state, active bank only
    logic [ADDR_BITS-1:0]   tag_mem [MAX_ENTRIES];
    logic [HANDLE_BITS-1:0] hnd_mem [MAX_ENTRIES];
    bit                     vld_mem [MAX_ENTRIES];
    logic [ADDR_BITS-1:0]   rehash_tag [MAX_ENTRIES];
    logic [HANDLE_BITS-1:0] rehash_hnd [MAX_ENTRIES];
    bit                     rehash_vld [MAX_ENTRIES];
    int unsigned page_shift_q;
    int unsigned init_log2_q;
    int unsigned size_log2;
    int unsigned live_entries;

    cache_req_t             req_queue [$];
    cache_result_t          awaited_results [$];
    logic [ADDR_BITS-1:0]   addr_pool [$];
    cache_req_t             next_req;

    int unsigned pushed_items   = 0;
    int unsigned accepted_items = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatches     = 0;
    int unsigned stalled_cycles = 0;
    int unsigned reg_writes     = 0;
    int unsigned n_lookup       = 0;
    int unsigned n_hit          = 0;
    int unsigned n_insert       = 0;
    int unsigned n_resize       = 0;
    int unsigned n_unused       = 0;
    int unsigned n_rejected     = 0;
    int unsigned n_clamped      = 0;

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int unsigned slot_of_addr(logic [ADDR_BITS-1:0] a, int unsigned l);
        return int'((a >> page_shift_q) & ((64'd1 << l) - 64'd1));
    endfunction

    function automatic void clear_cache();
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            tag_mem[i] = '1;
            hnd_mem[i] = '0;
            vld_mem[i] = 1'b0;
        end
        live_entries = 0;
        size_log2    = (init_log2_q > MAX_LOG2) ? MAX_LOG2 : init_log2_q;
    endfunction

    function automatic cache_result_t apply_cache_op(cache_req_t r);
        cache_result_t res;
        int unsigned   s;
        int unsigned   l;
        int unsigned   d;
        logic [NEW_SIZE_W-1:0] v;
        res        = '0;
        res.status = STAT_OK;
        case (r.op)
            OP_LOOKUP: begin
                s              = slot_of_addr(r.addr, size_log2);
                res.hit        = vld_mem[s] && (tag_mem[s] == r.addr);
                res.handle_out = hnd_mem[s];
            end
            OP_INSERT: begin
                s = slot_of_addr(r.addr, size_log2);
                if (hnd_mem[s] == '0 && r.handle != '0) begin
                    live_entries++;
                end else if (hnd_mem[s] != '0 && r.handle == '0) begin
                    live_entries--;
                end
                tag_mem[s]     = r.addr;
                hnd_mem[s]     = r.handle;
                vld_mem[s]     = 1'b1;
                res.handle_out = r.handle;
            end
            OP_RESIZE: begin
                if (r.new_size == '0) begin
                    res.status = STAT_ZERO;
                end else begin
                    l = 0;
                    v = r.new_size;
                    while (v > 1) begin
                        v = v >> 1;
                        l++;
                    end
                    if (l > MAX_LOG2) begin
                        l          = MAX_LOG2;
                        res.status = STAT_CLAMP;
                    end
                    if (l != size_log2) begin
                        for (int i = 0; i < (1 << l); i++) begin
                            rehash_tag[i] = '1;
                            rehash_hnd[i] = '0;
                            rehash_vld[i] = 1'b0;
                        end
                        // first entry wins a collision unless its handle is zero
                        for (int i = 0; i < (1 << size_log2); i++) begin
                            if (vld_mem[i]) begin
                                d = slot_of_addr(tag_mem[i], l);
                                if (rehash_hnd[d] == '0) begin
                                    rehash_tag[d] = tag_mem[i];
                                    rehash_hnd[d] = hnd_mem[i];
                                    rehash_vld[d] = 1'b1;
                                end
                            end
                        end
                        live_entries = 0;
                        for (int i = 0; i < (1 << l); i++) begin
                            tag_mem[i] = rehash_tag[i];
                            hnd_mem[i] = rehash_hnd[i];
                            vld_mem[i] = rehash_vld[i];
                            if (rehash_hnd[i] != '0) begin
                                live_entries++;
                            end
                        end
                        size_log2 = l;
                    end
                end
            end
            default: begin
            end
        endcase
        res.entry_count = COUNT_W'(live_entries);
        return res;
    endfunction

    function automatic logic [ADDR_BITS-1:0] pick_addr();
        logic [ADDR_BITS-1:0] a;
        int unsigned          r;
        r = $urandom_range(99);
        if (r < 10) begin
            a = {$urandom, $urandom};
        end else if (r < 12) begin
            a = '1;
        end else if (r < 14) begin
            a = '0;
        end else begin
            a = {16'($urandom_range(3)) * 16'h5555, 48'h0};
            a = a | (64'($urandom_range(127)) << page_shift_q);
            a = a | ({$urandom, $urandom} & ((64'd1 << page_shift_q) - 64'd1));
        end
        return a;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        mismatches++;
        if (mismatches <= MAX_PRINTS) begin
            $display("mismatch on %s at result %0d: got %0h, want %0h",
                     what, results_seen, got, want);
        end
    endtask

    task automatic push_req(input t_op op, input logic [ADDR_BITS-1:0] addr,
                            input logic [HANDLE_BITS-1:0] handle,
                            input logic [NEW_SIZE_W-1:0] new_size);
        req_queue.push_back(cache_req_t'{op, addr, handle, new_size});
        pushed_items++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(negedge i_clk); while (!cfg_fire);
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (accepted_items != pushed_items || awaited_results.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (4) @(negedge i_clk);
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (i_rst_n && (!in_valid || in_fire)) begin
            if (req_queue.size() != 0 && (no_idle || $urandom_range(99) >= IDLE_PCT)) begin
                next_req = req_queue.pop_front();
                in_valid    <= 1'b1;
                in_op       <= next_req.op;
                in_addr     <= next_req.addr;
                in_handle   <= next_req.handle;
                in_new_size <= next_req.new_size;
            end else begin
                in_valid <= 1'b0;
            end
        end
    end

    // result stalls
    always @(negedge i_clk) begin
        out_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
    end

    always @(posedge i_clk) begin : monitor
        cache_result_t want;
        in_fire  <= in_valid && in_if.ready;
        cfg_fire <= cfg_valid && cfg_if.ready;
        if (i_rst_n) begin
            if (out_if.valid && out_ready) begin
                results_seen++;
                if (awaited_results.size() == 0) begin
                    report_mismatch("result with no transaction pending", '0, '0);
                end else begin
                    want = awaited_results.pop_front();
                    if (out_if.hit !== want.hit) begin
                        report_mismatch("hit", out_if.hit, want.hit);
                    end
                    if (out_if.handle_out !== want.handle_out) begin
                        report_mismatch("handle_out", out_if.handle_out, want.handle_out);
                    end
                    if (out_if.entry_count !== want.entry_count) begin
                        report_mismatch("entry_count", out_if.entry_count, want.entry_count);
                    end
                    if (out_if.status !== want.status) begin
                        report_mismatch("status", out_if.status, want.status);
                    end
                end
            end
            if (cfg_valid && cfg_if.ready) begin
                reg_writes++;
                if (cfg_index == CFG_PAGE_SHIFT) begin
                    page_shift_q = cfg_data;
                end else if (cfg_index == CFG_INIT_SIZE) begin
                    init_log2_q = cfg_data[3:0];
                    clear_cache();
                end
            end
            if (in_valid && in_if.ready) begin
                want = apply_cache_op(cache_req_t'{in_op, in_addr, in_handle, in_new_size});
                awaited_results.push_back(want);
                accepted_items++;
                case (in_op)
                    OP_LOOKUP: begin
                        n_lookup++;
                        if (want.hit) begin
                            n_hit++;
                        end
                    end
                    OP_INSERT: n_insert++;
                    OP_RESIZE: begin
                        n_resize++;
                        if (want.status == STAT_ZERO) begin
                            n_rejected++;
                        end
                        if (want.status == STAT_CLAMP) begin
                            n_clamped++;
                        end
                    end
                    default: n_unused++;
                endcase
            end
            if ((in_valid && in_if.ready) || (out_if.valid && out_ready) ||
                (cfg_valid && cfg_if.ready)) begin
                stalled_cycles = 0;
            end else begin
                stalled_cycles++;
            end
            if (stalled_cycles >= WATCHDOG_LIMIT) begin
                $display("timeout: no transaction for %0d cycles", stalled_cycles);
                $display("direct_mapped_page_tag_cache regression: fail");
                $finish;
            end
        end
    end

    initial begin : stimulus
        cache_req_t  r;
        int unsigned pick;
        page_shift_q = PAGE_SHIFT_RESET;
        init_log2_q  = INIT_SIZE_RESET;
        clear_cache();
        repeat (3) @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset config: 4 KiB pages, 1024 slots
        push_req(OP_LOOKUP, 64'h0, 32'h0, 21'h0);
        push_req(OP_INSERT, 64'h0, 32'hFFFF_FFFF, 21'h0);
        push_req(OP_LOOKUP, 64'h0, 32'h1234, 21'h1F_FFFF);
        push_req(OP_INSERT, '1, 32'h1, 21'h0);
        push_req(OP_LOOKUP, '1, 32'h0, 21'h0);
        push_req(OP_INSERT, 64'h2000, 32'h0, 21'h0);
        push_req(OP_LOOKUP, 64'h2000, 32'h0, 21'h0);
        push_req(OP_INSERT, 64'h6000, 32'h9, 21'h0);
        push_req(OP_INSERT, 64'h1000, 32'h5, 21'h0);
        push_req(OP_INSERT, 64'h5000, 32'h6, 21'h0);
        push_req(OP_INSERT, 64'h1000, 32'h0, 21'h0);
        push_req(OP_INSERT, 64'h1000, 32'h5, 21'h0);
        push_req(OP_INSERT, 64'h40_1000, 32'h7, 21'h0);
        push_req(OP_LOOKUP, 64'h1000, 32'h0, 21'h0);
        push_req(OP_NONE, '1, '1, '1);
        push_req(OP_RESIZE, 64'h0, 32'h0, 21'h0);
        push_req(OP_RESIZE, 64'h0, 32'h0, 21'h10_0000);
        push_req(OP_RESIZE, 64'h0, 32'h0, 21'd4096);
        push_req(OP_RESIZE, '1, '1, 21'h1F_FFFF);
        push_req(OP_RESIZE, 64'h0, 32'h0, 21'd3);
        push_req(OP_LOOKUP, 64'h6000, 32'h0, 21'h0);
        push_req(OP_RESIZE, 64'h0, 32'h0, 21'd1);
        push_req(OP_INSERT, 64'hFFFF_0000_0000_0000, 32'hA5A5_A5A5, 21'h0);
        push_req(OP_LOOKUP, 64'h0, 32'h0, 21'h0);
        push_req(OP_RESIZE, 64'h0, 32'h0, 21'd100);
        // hold off until the cache has answered everything
        wait_drained();

        for (int phase = 0; phase < PHASES; phase++) begin
            case (phase)
                0: begin
                    write_reg(CFG_PAGE_SHIFT, 5'd0);
                    write_reg(CFG_INIT_SIZE, 5'd0);
                end
                1: begin
                    write_reg(CFG_PAGE_SHIFT, 5'd20);
                    write_reg(CFG_INIT_SIZE, 5'd12);
                end
                2: begin
                    write_reg(CFG_PAGE_SHIFT, 5'd31);
                    write_reg(CFG_INIT_SIZE, 5'd15);
                end
                3: begin
                    write_reg(CFG_PAGE_SHIFT, CFG_DATA_W'($urandom_range(31)));
                    write_reg(CFG_INIT_SIZE, CFG_DATA_W'($urandom_range(9)));
                end
                default: begin
                    write_reg(CFG_INIT_SIZE, CFG_DATA_W'($urandom_range(15)));
                    write_reg(CFG_PAGE_SHIFT, 5'd12);
                end
            endcase
            no_idle = (phase == 2);
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                pick = $urandom_range(99);
                r.op = (pick < 40) ? OP_LOOKUP :
                       (pick < 80) ? OP_INSERT :
                       (pick < 94) ? OP_RESIZE : OP_NONE;
                // lookups mostly revisit addresses that were inserted
                if (r.op == OP_LOOKUP && addr_pool.size() != 0 && $urandom_range(99) < 70) begin
                    r.addr = addr_pool[$urandom_range(addr_pool.size() - 1)];
                end else begin
                    r.addr = pick_addr();
                end
                pick = $urandom_range(99);
                r.handle = (pick < 10) ? '0 : (pick < 13) ? '1 : HANDLE_BITS'($urandom);
                pick = $urandom_range(99);
                if (r.op != OP_RESIZE) begin
                    r.new_size = NEW_SIZE_W'($urandom);
                end else if (pick < 8) begin
                    r.new_size = '0;
                end else if (pick < 11) begin
                    r.new_size = NEW_SIZE_W'($urandom_range(4096, 2 ** NEW_SIZE_W - 1));
                end else if (pick < 12) begin
                    r.new_size = '1;
                end else begin
                    r.new_size = NEW_SIZE_W'($urandom_range(1, 128));
                end
                if (r.op == OP_INSERT) begin
                    addr_pool.push_back(r.addr);
                    if (addr_pool.size() > POOL_DEPTH) begin
                        void'(addr_pool.pop_front());
                    end
                end
                push_req(r.op, r.addr, r.handle, r.new_size);
            end
            wait_drained();
        end
        no_idle = 1'b0;

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        $display("ran %0d transactions: %0d lookups (%0d hits), %0d inserts, %0d resizes, %0d unused op",
                 accepted_items, n_lookup, n_hit, n_insert, n_resize, n_unused);
        $display("%0d register writes, %0d zero-size and %0d clamped resizes, %0d mismatches",
                 reg_writes, n_rejected, n_clamped, mismatches);
        if (mismatches == 0) begin
            $display("direct_mapped_page_tag_cache regression: pass");
        end else begin
            $display("direct_mapped_page_tag_cache regression: fail");
        end
        $finish;
    end

endmodule

// ----- sim.f -----
+incdir+hdl
hdl/dmptc_pkg.sv
hdl/dmptc_if.sv
hdl/dmptc_ctrl.sv
hdl/dmptc_datapath.sv
hdl/direct_mapped_page_tag_cache.sv
dv/tb_top.sv
